/* rtl/core/sfc_pkg.sv */
package sfc_pkg;

  // Default fraction bits of sample, offset and reciprocal registers.
  localparam int FRAC_BITS_DEFAULT = 16;

  // Curve arithmetic: fraction bits, accumulator and abscissa widths.
  localparam int PQ    = 24;
  localparam int ACC_W = 36;
  localparam int X_W   = PQ + 1;
  localparam int NSTEP = 5;

  // Round(2^32 / (2*pi)), turns per radian with 32 fraction bits.
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;

  // Scale modes.
  localparam logic [1:0] MODE_LINEAR  = 2'd0;
  localparam logic [1:0] MODE_DECIBEL = 2'd1;
  localparam logic [1:0] MODE_PHASE   = 2'd2;

  // Colormap kinds.
  localparam logic [1:0] KIND_GRAY    = 2'd0;
  localparam logic [1:0] KIND_INFERNO = 2'd1;
  localparam logic [1:0] KIND_TURBO   = 2'd2;
  localparam logic [1:0] KIND_HUE     = 2'd3;

  // Register indexes.
  localparam logic [2:0] CFG_MODE    = 3'd0;
  localparam logic [2:0] CFG_KIND    = 3'd1;
  localparam logic [2:0] CFG_OFFSET  = 3'd2;
  localparam logic [2:0] CFG_INV     = 3'd3;
  localparam logic [2:0] CFG_INVALID = 3'd4;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               sample_valid;
  } sample_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       negative_error;
  } pixel_t;

  // Side information that travels with each beat.
  typedef struct packed {
    logic valid;
    logic err;
    logic inv;
    logic use_hue;
  } meta_t;

  localparam longint PSCALE = 64'sd16777216;
  localparam longint CQH    = 64'sd50000000;
  localparam longint CQD    = 64'sd100000000;

  // Decimal coefficient scaled by 1e8, rounded to PQ fraction bits.
  function automatic longint cq(input longint n);
    return (n * PSCALE + CQH) / CQD;
  endfunction

  localparam longint TURBO [3][6] = '{
    '{cq(13572138), cq(461539260), -cq(64'sd4266032258), cq(64'sd13213108234),
      -cq(64'sd15294239396), cq(64'sd5928637943)},
    '{cq(9140261), cq(219418839), cq(484296658), -cq(1418503333),
      cq(427729857), cq(282956604)},
    '{cq(10667330), cq(1259254356), -cq(64'sd6001802309), cq(64'sd10907409214),
      -cq(64'sd8850849206), cq(64'sd2686134844)}
  };

  // Cubic curves padded with zero high terms so they share the quintic chain.
  localparam longint INFERNO [3][6] = '{
    '{-cq(240000), cq(97800000), cq(213800000), -cq(211500000), 64'sd0, 64'sd0},
    '{cq(160000), -cq(34700000), cq(304800000), -cq(170500000), 64'sd0, 64'sd0},
    '{cq(1300000), cq(359300000), -cq(894800000), cq(534200000), 64'sd0, 64'sd0}
  };

  // Coefficient j of channel chan; grayscale is the identity polynomial.
  function automatic acc_t coef(input logic [1:0] kind, input int chan, input int j);
    acc_t c;
    c = '0;
    case (kind)
      KIND_INFERNO: c = ACC_W'(INFERNO[chan][j]);
      KIND_TURBO:   c = ACC_W'(TURBO[chan][j]);
      KIND_GRAY:    c = (j == 1) ? ACC_W'(PSCALE) : '0;
      default:      c = '0;
    endcase
    return c;
  endfunction

  // Clamp to [0,1] and round to a byte.
  function automatic logic [7:0] to_byte(input acc_t v);
    logic [PQ+7:0] t;
    t = '0;
    if (v <= 0) begin
      return 8'd0;
    end
    if (v >= acc_t'(PSCALE)) begin
      return 8'd255;
    end
    t = (PQ+8)'(v[PQ-1:0]) * (PQ+8)'(255) + ((PQ+8)'(1) << (PQ - 1));
    return t[PQ+7:PQ];
  endfunction

endpackage

/* rtl/core/sfc_scale.sv */
module sfc_scale #(
  parameter int FRAC_BITS = sfc_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  sfc_pkg::sample_t        sample_i,
  input  logic [1:0]              mode_i,
  input  logic [1:0]              kind_i,
  input  logic [31:0]             offset_i,
  input  logic [31:0]             inv_i,
  output sfc_pkg::meta_t          meta_o,
  output logic [sfc_pkg::X_W-1:0] x_o,
  output logic [31:0]             turn_o
);
  import sfc_pkg::*;

  localparam int PW = 66;
  localparam logic [PW-FRAC_BITS-1:0] ONE = (PW-FRAC_BITS)'(1) << FRAC_BITS;

  meta_t               meta1_q, meta2_q, meta3_q;
  logic signed [32:0]  a_d, a_q, b_d, b_q, diff;
  logic signed [PW-1:0] prod_q;
  logic [PW-FRAC_BITS-1:0] hi;
  logic [FRAC_BITS:0]  norm;
  logic [X_W-1:0]      x_d, x_q;
  logic [31:0]         turn_d, turn_q;
  logic                err_d;

  // Stage one: offset, sign check and multiplier operands.
  always_comb begin
    diff = {sample_i.sample_value[31], sample_i.sample_value};
    if (mode_i == MODE_DECIBEL) begin
      diff = {sample_i.sample_value[31], sample_i.sample_value}
             - {offset_i[31], offset_i};
    end
    err_d = (mode_i != MODE_DECIBEL) && (mode_i != MODE_PHASE)
            && sample_i.sample_value[31];
    if (mode_i == MODE_PHASE) begin
      a_d = {sample_i.sample_value[31], sample_i.sample_value};
      b_d = {3'b000, INV_TWO_PI};
    end else begin
      a_d = (diff > 0) ? diff : '0;
      b_d = {1'b0, inv_i};
    end
  end

  // Side information (valid, error, invalid and hue flags) of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta1_q <= '0;
      meta2_q <= '0;
      meta3_q <= '0;
    end else begin
      meta1_q <= '{valid: in_valid_i, err: err_d, inv: !sample_i.sample_valid,
                   use_hue: (mode_i == MODE_PHASE) || (kind_i == KIND_HUE)};
      meta2_q <= meta1_q;
      meta3_q <= meta2_q;
    end
  end

  // Stage three: saturate the norm, or wrap the phase into a turn.
  always_comb begin
    hi   = prod_q[PW-1:FRAC_BITS];
    norm = (hi > ONE) ? ONE[FRAC_BITS:0] : hi[FRAC_BITS:0];
    x_d  = {norm, {(PQ-FRAC_BITS){1'b0}}};
    if (mode_i == MODE_PHASE) begin
      turn_d = prod_q[FRAC_BITS+31:FRAC_BITS] + 32'h8000_0000;
    end else begin
      turn_d = {norm[FRAC_BITS-1:0], {(32-FRAC_BITS){1'b0}}};
    end
  end

  // Payload stages.
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    prod_q <= PW'(a_q) * PW'(b_q);
    x_q    <= x_d;
    turn_q <= turn_d;
  end

  assign meta_o = meta3_q;
  assign x_o    = x_q;
  assign turn_o = turn_q;

endmodule

/* rtl/core/sfc_horner_step.sv */
module sfc_horner_step #(
  parameter int J = 4
) (
  input  logic                    clk_i,
  input  logic [1:0]              kind_i,
  input  sfc_pkg::acc_t           acc_i [3],
  input  logic [sfc_pkg::X_W-1:0] x_i,
  output sfc_pkg::acc_t           acc_o [3],
  output logic [sfc_pkg::X_W-1:0] x_o
);
  import sfc_pkg::*;

  acc_t                acc_d [3];
  acc_t                acc_q [3];
  logic [ACC_W-1:0]    mag   [3];
  logic [ACC_W+X_W-1:0] prod [3];
  logic [X_W-1:0]      x_q;

  // One Horner step per channel: acc = c[J] + acc*x, product truncated toward zero.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mag[ch]   = acc_i[ch][ACC_W-1] ? ACC_W'(-acc_i[ch]) : ACC_W'(acc_i[ch]);
      prod[ch]  = (ACC_W+X_W)'(mag[ch]) * (ACC_W+X_W)'(x_i);
      acc_d[ch] = acc_i[ch][ACC_W-1]
                  ? coef(kind_i, ch, J) - acc_t'(prod[ch][ACC_W+PQ-1:PQ])
                  : coef(kind_i, ch, J) + acc_t'(prod[ch][ACC_W+PQ-1:PQ]);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_i;
  end

  assign acc_o = acc_q;
  assign x_o   = x_q;

endmodule

/* rtl/core/sfc_hue.sv */
module sfc_hue (
  input  logic        clk_i,
  input  logic [31:0] turn_i,
  output logic [7:0]  rgb_o [3]
);
  import sfc_pkg::*;

  logic [34:0] h;
  logic [2:0]  sector;
  logic [32:0] f, fd;
  logic [40:0] up_s, down_s;
  logic [7:0]  up, down;
  logic [7:0]  rgb_d [3];
  logic [7:0]  rgb_q [3];

  // Split the turn into six sectors and round the ramp to bytes.
  always_comb begin
    h      = 35'(turn_i) * 35'd6;
    sector = h[34:32];
    f      = {1'b0, h[31:0]};
    fd     = 33'h1_0000_0000 - f;
    up_s   = (41'(f) << 8) - 41'(f) + 41'h0_8000_0000;
    down_s = (41'(fd) << 8) - 41'(fd) + 41'h0_8000_0000;
    up     = (up_s[40:32] > 9'd255) ? 8'd255 : up_s[39:32];
    down   = (down_s[40:32] > 9'd255) ? 8'd255 : down_s[39:32];
    case (sector)
      3'd0:    rgb_d = '{8'd255, up, 8'd0};
      3'd1:    rgb_d = '{down, 8'd255, 8'd0};
      3'd2:    rgb_d = '{8'd0, 8'd255, up};
      3'd3:    rgb_d = '{8'd0, down, 8'd255};
      3'd4:    rgb_d = '{up, 8'd0, 8'd255};
      default: rgb_d = '{8'd255, 8'd0, down};
    endcase
  end

  always_ff @(posedge clk_i) begin
    rgb_q <= rgb_d;
  end

  assign rgb_o = rgb_q;

endmodule

/* rtl/core/scalar_field_colormap_pixel.sv */
// Scalar field to RGBA colormap, one pixel per sample.
// Input channel: a sample beat is taken at each rising edge with start high
// and busy low. busy is held low, so a new sample may enter on every cycle.
// Output channel: result_valid_o marks each pixel for exactly one cycle;
// the receiver takes it at the edge that ends that cycle and cannot stall.
// Path: the pixel reaches the outputs through the chain of nine register
// stages: operand setup, the sample times reciprocal multiply,
// normalization, five Horner steps of the quintic curve (one multiply each)
// and the byte rounding stage.
// Throughput: one pixel per clock, sustained, in every mode.
// Configuration: a write at index i, with cfg_we_i high, loads register i;
// the user changes registers only while no sample is in flight (not enforced).
// Reset: all valid bits clear and the registers take their reset values;
// no pixel is emitted until a new sample arrives.
module scalar_field_colormap_pixel #(
  parameter int FRAC_BITS = sfc_pkg::FRAC_BITS_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  sfc_pkg::sample_t sample_i,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  output logic             result_valid_o,
  output sfc_pkg::pixel_t  result_o
);
  import sfc_pkg::*;

  logic [1:0]  mode_q, kind_q;
  logic [31:0] offset_q, inv_q, invalid_q;

  meta_t          meta3;
  meta_t          meta_q [NSTEP];
  logic [X_W-1:0] x_w   [NSTEP+1];
  acc_t           acc_w [NSTEP+1][3];
  logic [31:0]    turn3;
  logic [7:0]     hue_w [3];
  logic [7:0]     hue_q [NSTEP-1][3];
  logic           valid_q;
  pixel_t         result_d, result_q;

  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_LINEAR;
      kind_q    <= KIND_TURBO;
      offset_q  <= '0;
      inv_q     <= 32'd65536;
      invalid_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:    mode_q    <= cfg_data_i[1:0];
        CFG_KIND:    kind_q    <= cfg_data_i[1:0];
        CFG_OFFSET:  offset_q  <= cfg_data_i;
        CFG_INV:     inv_q     <= cfg_data_i;
        CFG_INVALID: invalid_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front end: scaling and normalization.
  sfc_scale #(
    .FRAC_BITS(FRAC_BITS)
  ) u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(start && !busy),
    .sample_i  (sample_i),
    .mode_i    (mode_q),
    .kind_i    (kind_q),
    .offset_i  (offset_q),
    .inv_i     (inv_q),
    .meta_o    (meta3),
    .x_o       (x_w[0]),
    .turn_o    (turn3)
  );

  // Hue wheel runs beside the first Horner step.
  sfc_hue u_hue (
    .clk_i (clk_i),
    .turn_i(turn3),
    .rgb_o (hue_w)
  );

  // Horner chain seeded with the leading coefficient.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc_w[0][ch] = coef(kind_q, ch, NSTEP);
    end
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    sfc_horner_step #(
      .J(NSTEP - 1 - k)
    ) u_step (
      .clk_i (clk_i),
      .kind_i(kind_q),
      .acc_i (acc_w[k]),
      .x_i   (x_w[k]),
      .acc_o (acc_w[k+1]),
      .x_o   (x_w[k+1])
    );
  end

  // Side information follows the Horner stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTEP; k++) begin
        meta_q[k] <= '0;
      end
      valid_q <= 1'b0;
    end else begin
      meta_q[0] <= meta3;
      for (int k = 1; k < NSTEP; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
      valid_q <= meta_q[NSTEP-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q[0] <= hue_w;
    for (int k = 1; k < NSTEP - 1; k++) begin
      hue_q[k] <= hue_q[k-1];
    end
    result_q <= result_d;
  end

  // Final stage: invalid color, hue bytes or rounded curve bytes.
  always_comb begin
    if (meta_q[NSTEP-1].inv) begin
      result_d = '{red: invalid_q[31:24], green: invalid_q[23:16],
                   blue: invalid_q[15:8], alpha: invalid_q[7:0],
                   negative_error: 1'b0};
    end else if (meta_q[NSTEP-1].use_hue) begin
      result_d = '{red: hue_q[NSTEP-2][0], green: hue_q[NSTEP-2][1],
                   blue: hue_q[NSTEP-2][2], alpha: 8'hFF,
                   negative_error: meta_q[NSTEP-1].err};
    end else begin
      result_d = '{red: to_byte(acc_w[NSTEP][0]), green: to_byte(acc_w[NSTEP][1]),
                   blue: to_byte(acc_w[NSTEP][2]), alpha: 8'hFF,
                   negative_error: meta_q[NSTEP-1].err};
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

  // A beat leaving the front end reaches the Horner chain.
  a_chain_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta3.valid |=> meta_q[0].valid)
    else $error("beat lost entering the curve chain");

  // The last stage always produces a strobe.
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta_q[NSTEP-1].valid |=> result_valid_o)
    else $error("beat lost at the output stage");

  // Mapped pixels are opaque.
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta_q[NSTEP-1].valid && !meta_q[NSTEP-1].inv |=> result_o.alpha == 8'hFF)
    else $error("mapped pixel without full alpha");

  // The error flag never appears in decibel or phase mode.
  a_err_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.negative_error
      |-> mode_q != MODE_DECIBEL && mode_q != MODE_PHASE)
    else $error("negative error outside linear mode");

endmodule

/* bench/tb.sv */
module tb;
  import sfc_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  sample_t     sample_i;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        result_valid_o;
  pixel_t      result_o;

  scalar_field_colormap_pixel dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .sample_i(sample_i),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .result_valid_o(result_valid_o), .result_o(result_o)
  );

  // Shadow copy of the configuration registers.
  logic [1:0]  scale_mode_q    = MODE_LINEAR;
  logic [1:0]  map_kind_q      = KIND_TURBO;
  logic [31:0] db_floor_q      = '0;
  logic [31:0] recip_range_q   = 32'd65536;
  logic [31:0] invalid_rgba_q  = '0;

  sample_t pending_samples[$];
  pixel_t  expected_pixels[$];
  int      send_idle_pct = 0;
  bit      send_hold = 0;
  int      errors = 0;

  localparam longint ONE_Q24 = 64'sd16777216;

  // Decimal constant scaled by 1e8, rounded to 24 fraction bits.
  function automatic longint dec_q24(input longint n);
    return (n * ONE_Q24 + 64'sd50000000) / 64'sd100000000;
  endfunction

  longint turbo_c [3][6] = '{
    '{dec_q24(13572138), dec_q24(461539260), -dec_q24(64'sd4266032258),
      dec_q24(64'sd13213108234), -dec_q24(64'sd15294239396), dec_q24(64'sd5928637943)},
    '{dec_q24(9140261), dec_q24(219418839), dec_q24(484296658),
      -dec_q24(1418503333), dec_q24(427729857), dec_q24(282956604)},
    '{dec_q24(10667330), dec_q24(1259254356), -dec_q24(64'sd6001802309),
      dec_q24(64'sd10907409214), -dec_q24(64'sd8850849206), dec_q24(64'sd2686134844)}
  };
  longint inferno_c [3][6] = '{
    '{-dec_q24(240000), dec_q24(97800000), dec_q24(213800000), -dec_q24(211500000), 0, 0},
    '{dec_q24(160000), -dec_q24(34700000), dec_q24(304800000), -dec_q24(170500000), 0, 0},
    '{dec_q24(1300000), dec_q24(359300000), -dec_q24(894800000), dec_q24(534200000), 0, 0}
  };

  // Product in Q24, truncated toward zero.
  function automatic longint mul_q24(input longint a, input longint x);
    longint unsigned mag;
    longint unsigned p;
    mag = (a < 0) ? longint'(-a) : a;
    p = (mag * longint'(x)) >> 24;
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint curve_eval(input logic [1:0] kind, input int chan,
                                        input longint x);
    longint acc;
    acc = 0;
    for (int i = 5; i >= 0; i--) begin
      acc = ((kind == KIND_TURBO) ? turbo_c[chan][i] : inferno_c[chan][i]) + mul_q24(acc, x);
    end
    return acc;
  endfunction

  function automatic logic [7:0] q24_to_byte(input longint v);
    if (v <= 0) begin
      return 8'd0;
    end
    if (v >= ONE_Q24) begin
      return 8'd255;
    end
    return 8'((v * 255 + 64'sd8388608) >>> 24);
  endfunction

  function automatic logic [7:0] frac32_to_byte(input longint unsigned f);
    longint unsigned b;
    b = (f * 255 + 64'h8000_0000) >> 32;
    return (b > 255) ? 8'd255 : 8'(b);
  endfunction

  // Six-sector hue wheel, red in the top byte.
  function automatic logic [23:0] hue_wheel(input logic [31:0] turn);
    longint unsigned h;
    longint unsigned f;
    logic [7:0] up;
    logic [7:0] down;
    h = longint'(turn) * 6;
    f = h & 64'hFFFF_FFFF;
    up = frac32_to_byte(f);
    down = frac32_to_byte(64'h1_0000_0000 - f);
    case (h >> 32)
      0: return {8'd255, up, 8'd0};
      1: return {down, 8'd255, 8'd0};
      2: return {8'd0, 8'd255, up};
      3: return {8'd0, down, 8'd255};
      4: return {up, 8'd0, 8'd255};
      default: return {8'd255, 8'd0, down};
    endcase
  endfunction

  // Expected pixel for one sample under the current register values.
  function automatic pixel_t predict_pixel(input sample_t smp);
    pixel_t px;
    logic signed [63:0] ph;
    longint s;
    longint d;
    longint unsigned norm;
    longint x;
    logic [23:0] rgb;
    px = '0;
    if (!smp.sample_valid) begin
      {px.red, px.green, px.blue, px.alpha} = invalid_rgba_q;
      return px;
    end
    s = longint'(smp.sample_value);
    if (scale_mode_q == MODE_PHASE) begin
      ph = s * 64'sd683565276;
      rgb = hue_wheel(ph[47:16] + 32'h8000_0000);
    end else begin
      d = s;
      norm = 0;
      if (scale_mode_q == MODE_DECIBEL) begin
        d = s - longint'($signed(db_floor_q));
      end else if (s < 0) begin
        px.negative_error = 1'b1;
      end
      if (d > 0) begin
        norm = (longint'(d) * longint'(recip_range_q)) >> 16;
        if (norm > 65536) begin
          norm = 65536;
        end
      end
      x = longint'(norm << 8);
      case (map_kind_q)
        KIND_GRAY: rgb = {3{q24_to_byte(x)}};
        KIND_INFERNO, KIND_TURBO: begin
          rgb = {q24_to_byte(curve_eval(map_kind_q, 0, x)),
                 q24_to_byte(curve_eval(map_kind_q, 1, x)),
                 q24_to_byte(curve_eval(map_kind_q, 2, x))};
        end
        default: rgb = hue_wheel(32'(norm << 16));
      endcase
    end
    {px.red, px.green, px.blue} = rgb;
    px.alpha = 8'd255;
    return px;
  endfunction

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sample driver: predicts each accepted beat and presents the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    bit taken;
    if (!rst_ni) begin
      start <= 1'b0;
      sample_i <= '0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        expected_pixels.push_back(predict_pixel(sample_i));
        void'(pending_samples.pop_front());
      end
      if (start && !taken) begin
        start <= 1'b1;
      end else if (pending_samples.size() > 0 && !send_hold &&
                   $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        sample_i <= pending_samples[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Pixel monitor.
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none, actual %h", $time, result_o);
      end else begin
        want = expected_pixels.pop_front();
        if (result_o !== want) begin
          errors++;
          $display("%0t: pixel mismatch, expected %h, actual %h", $time, want, result_o);
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MODE:    scale_mode_q = data[1:0];
      CFG_KIND:    map_kind_q = data[1:0];
      CFG_OFFSET:  db_floor_q = data;
      CFG_INV:     recip_range_q = data;
      default:     invalid_rgba_q = data;
    endcase
  endtask

  // Wait until every sample was taken and every pixel has come out.
  task automatic drain();
    while (pending_samples.size() != 0 || start || expected_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (12) @(posedge clk_i);
  endtask

  function automatic sample_t sample_of(input logic [31:0] v, input logic ok);
    sample_t smp;
    smp.sample_value = v;
    smp.sample_valid = ok;
    return smp;
  endfunction

  // Random sample, mostly inside the span that maps onto the colormap.
  function automatic sample_t random_sample();
    longint t;
    longint d;
    int cls;
    cls = $urandom_range(9);
    if (cls <= 1) begin
      return sample_of($urandom, 1'b1);
    end
    if (cls == 2) begin
      return sample_of((scale_mode_q == MODE_DECIBEL) ? db_floor_q : 32'd0, 1'b1);
    end
    if (cls == 3) begin
      return sample_of($urandom, 1'b0);
    end
    if (scale_mode_q == MODE_PHASE) begin
      return sample_of(32'($signed($urandom_range(0, 900000)) - 450000), 1'b1);
    end
    t = $urandom_range(0, 72000);
    d = (recip_range_q == 0) ? t : (t * 65536) / longint'(recip_range_q);
    if ($urandom_range(9) == 0) begin
      d = -d;
    end
    if (scale_mode_q == MODE_DECIBEL) begin
      d = d + longint'($signed(db_floor_q));
    end
    if (d > 64'sh7FFF_FFFF) begin
      d = 64'sh7FFF_FFFF;
    end
    if (d < -64'sh8000_0000) begin
      d = -64'sh8000_0000;
    end
    return sample_of(32'(d), 1'b1);
  endfunction

  // Stimulus sequence.
  initial begin
    int idle_set [4] = '{0, 71, 0, 34};
    logic [31:0] inv_val;
    logic [31:0] off_val;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_MODE;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners, first under the reset configuration, then in phase and decibel mode.
    pending_samples.push_back(sample_of(32'd0, 1'b1));
    pending_samples.push_back(sample_of(32'd65536, 1'b1));
    pending_samples.push_back(sample_of(32'd32768, 1'b1));
    pending_samples.push_back(sample_of(32'h7FFF_FFFF, 1'b1));
    pending_samples.push_back(sample_of(32'h8000_0000, 1'b1));
    pending_samples.push_back(sample_of(32'hFFFF_FFFF, 1'b1));
    pending_samples.push_back(sample_of(32'h7FFF_FFFF, 1'b0));
    drain();
    write_reg(CFG_INVALID, 32'hFFFF_FFFF);
    write_reg(CFG_MODE, MODE_PHASE);
    pending_samples.push_back(sample_of(32'd0, 1'b0));
    pending_samples.push_back(sample_of(32'd0, 1'b1));
    pending_samples.push_back(sample_of(32'd205887, 1'b1));
    pending_samples.push_back(sample_of(32'hFFFC_DC41, 1'b1));
    pending_samples.push_back(sample_of(32'h7FFF_FFFF, 1'b1));
    pending_samples.push_back(sample_of(32'h8000_0000, 1'b1));
    drain();
    write_reg(CFG_MODE, MODE_DECIBEL);
    write_reg(CFG_OFFSET, 32'h8000_0000);
    write_reg(CFG_INV, 32'hFFFF_FFFF);
    pending_samples.push_back(sample_of(32'h8000_0000, 1'b1));
    pending_samples.push_back(sample_of(32'h7FFF_FFFF, 1'b1));
    pending_samples.push_back(sample_of(32'h8000_0001, 1'b1));
    drain();

    // Randomized phases, each with its own register setting and idling.
    for (int p = 0; p < 24; p++) begin
      case (p % 6)
        0: inv_val = 32'd65536;
        1: inv_val = 32'd0;
        2: inv_val = 32'hFFFF_FFFF;
        default: inv_val = $urandom_range(1 << 12, 1 << 20);
      endcase
      case (p % 5)
        0: off_val = 32'h7FFF_FFFF;
        1: off_val = 32'h8000_0000;
        2: off_val = 32'd0;
        default: off_val = $urandom_range(0, 1 << 22) - (1 << 21);
      endcase
      write_reg(CFG_MODE, 2'(p % 4));
      write_reg(CFG_KIND, 2'((p / 4) % 4));
      write_reg(CFG_OFFSET, off_val);
      write_reg(CFG_INV, inv_val);
      write_reg(CFG_INVALID, (p % 7 == 0) ? 32'd0 : $urandom);
      send_idle_pct = idle_set[p % 4];
      for (int i = 0; i < 72; i++) begin
        pending_samples.push_back(random_sample());
        // Midway through one phase, hold the sender until the pipe is empty.
        if (p == 3 && i == 36) begin
          while (pending_samples.size() > 0 || start) @(posedge clk_i);
          send_hold = 1;
          while (expected_pixels.size() != 0) @(posedge clk_i);
          send_hold = 0;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/sfc_pkg.sv
rtl/core/sfc_scale.sv
rtl/core/sfc_horner_step.sv
rtl/core/sfc_hue.sv
rtl/core/scalar_field_colormap_pixel.sv
bench/tb.sv
